[rtl/c2c_pkg.sv]
// Shared types and constants for the COO to CSC converter.
// No dependencies; imported by every module of the block.
package c2c_pkg;

  localparam int MaxEntries = 4096;
  localparam int MaxCols    = 4096;
  localparam int AddrW      = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);

  localparam logic [1:0] CmdLoad    = 2'd0;
  localparam logic [1:0] CmdReadPtr = 2'd1;
  localparam logic [1:0] CmdReadEnt = 2'd2;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StCol     = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StIndex   = 3'd3;
  localparam logic [2:0] StNotConv = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic [14:0]        row;
    logic [11:0]        col;
    logic signed [15:0] value;
    logic               last;
    logic [12:0]        index;
  } c2c_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [12:0]        col_start;
    logic [14:0]        row_out;
    logic signed [15:0] value_out;
    logic [12:0]        entry_count;
  } c2c_out_t;

  // one stored nonzero; {col, row} is the sort key
  typedef struct packed {
    logic [11:0]        col;
    logic [14:0]        row;
    logic signed [15:0] value;
  } entry_t;

  // broadcast control for the cell row
  typedef struct packed {
    logic   ins;
    logic   shift;
    entry_t new_e;
  } chain_ctl_t;

endpackage

[rtl/c2c_cell.sv]
// One cell of the sorting row: holds one entry, inserts in key order.
// Depends on c2c_pkg.
module c2c_cell
  import c2c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_ctl_t ctl_i,
  input  entry_t     left_e_i,
  input  logic       left_v_i,
  input  logic       left_keep_i,
  input  entry_t     right_e_i,
  input  logic       right_v_i,
  output entry_t     e_o,
  output logic       v_o,
  output logic       keep_o
);

  entry_t e_q, e_d;
  logic   v_q, v_d;

  // keep: this entry sorts at or before the new one (equal keys stay first)
  assign keep_o = v_q && ({e_q.col, e_q.row} <= {ctl_i.new_e.col, ctl_i.new_e.row});

  always_comb begin
    e_d = e_q;
    v_d = v_q;
    if (ctl_i.ins) begin
      if (keep_o) begin
        e_d = e_q;
      end else if (!left_keep_i) begin
        e_d = left_e_i;
        v_d = left_v_i;
      end else begin
        e_d = ctl_i.new_e;
        v_d = 1'b1;
      end
    end else if (ctl_i.shift) begin
      e_d = right_e_i;
      v_d = right_v_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
  end

  assign e_o = e_q;
  assign v_o = v_q;

endmodule

[rtl/c2c_chain.sv]
// Row of MaxEntries sorting cells; head cell drains out first.
// Depends on c2c_pkg and c2c_cell.
module c2c_chain
  import c2c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_ctl_t ctl_i,
  output entry_t     head_e_o,
  output logic       head_v_o
);

  entry_t e_w    [MaxEntries];
  logic   v_w    [MaxEntries];
  logic   keep_w [MaxEntries];

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    entry_t le, re;
    logic   lv, lk, rv;
    if (i == 0) begin : g_first
      assign le = '0;
      assign lv = 1'b0;
      assign lk = 1'b1;
    end else begin : g_mid
      assign le = e_w[i-1];
      assign lv = v_w[i-1];
      assign lk = keep_w[i-1];
    end
    if (i == MaxEntries - 1) begin : g_last
      assign re = '0;
      assign rv = 1'b0;
    end else begin : g_nlast
      assign re = e_w[i+1];
      assign rv = v_w[i+1];
    end
    c2c_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .left_e_i    (le),
      .left_v_i    (lv),
      .left_keep_i (lk),
      .right_e_i   (re),
      .right_v_i   (rv),
      .e_o         (e_w[i]),
      .v_o         (v_w[i]),
      .keep_o      (keep_w[i])
    );
  end

  assign head_e_o = e_w[0];
  assign head_v_o = v_w[0];

endmodule

[rtl/coo_to_csc_converter_unit.sv]
// Top level of the COO to CSC converter: control, cell row, sorted entry memory.
// Depends on c2c_pkg and c2c_chain.
//
// Usage: a command is a transfer on item_i at a clock edge with start_i high
// and busy_o low. Each command gives one result on result_o, marked by
// result_valid_o for one cycle; the receiver cannot stall it.
// Loads enter a row of cells that keeps them sorted by (col, row), arrival
// order kept for equal keys, one load per cycle while idle; the result follows
// next cycle. A load marked last then drains the row into the entry memory,
// one entry per cycle, busy meanwhile. Column pointers are not stored: a pointer
// read is a binary search for the first entry with col >= index over the
// sorted memory, each step a memory read and then a compare. An entry read is
// a registered memory read. Error results, like loads, follow next cycle.
// num_cols is written through cfg_we_i / cfg_data_i; the user must write it
// only while idle, the block itself has no check for it. Reset empties the cell
// row, clears the count and the converted flag and sets num_cols to 4096; the
// memory is not cleared, only entries below the count are ever read.
module coo_to_csc_converter_unit
  import c2c_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  c2c_in_t  item_i,
  output logic     result_valid_o,
  output c2c_out_t result_o,
  input  logic     cfg_we_i,
  input  logic [12:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DRAIN = 5'b00010,
    S_RDENT = 5'b00100,
    S_SRCH  = 5'b01000,
    S_SCMP  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [12:0]     num_cols_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            conv_q, conv_d;
  logic [12:0]     conv_cols_q, conv_cols_d;
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [12:0]     idx_q, idx_d;
  logic            res_v_q, res_v_d;
  c2c_out_t        res_q, res_d;

  entry_t          mem [MaxEntries];
  entry_t          rd_q;
  logic            rd_en;
  logic [AddrW-1:0] rd_addr;

  chain_ctl_t      ctl;
  entry_t          head_e;
  logic            head_v;

  logic [12:0]     eff_cols;
  logic            accept;
  logic [CntW-1:0] base_cnt, new_cnt;
  logic            col_bad, full;
  logic [CntW:0]   mid_sum;

  assign accept   = start_i && (state_q == S_IDLE);
  assign eff_cols = (num_cols_q > 13'(MaxCols)) ? 13'(MaxCols) : num_cols_q;
  // a load after a conversion starts a new set
  assign base_cnt = conv_q ? '0 : cnt_q;
  assign col_bad  = {1'b0, item_i.col} >= eff_cols;
  assign full     = base_cnt == CntW'(MaxEntries);
  assign new_cnt  = base_cnt + CntW'(!col_bad && !full);
  assign mid_sum  = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    conv_d      = conv_q;
    conv_cols_d = conv_cols_q;
    wr_ptr_d    = wr_ptr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    res_v_d     = 1'b0;
    res_d       = '0;
    res_d.entry_count = 13'(cnt_q);
    rd_en       = 1'b0;
    rd_addr     = item_i.index[AddrW-1:0];
    ctl         = '0;
    ctl.new_e   = '{col: item_i.col, row: item_i.row, value: item_i.value};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d = item_i.index;
          case (item_i.command)
            CmdLoad: begin
              res_v_d = 1'b1;
              res_d.status = col_bad ? StCol : (full ? StFull : StOk);
              res_d.entry_count = 13'(new_cnt);
              ctl.ins = !col_bad && !full;
              cnt_d   = new_cnt;
              conv_d  = item_i.last;
              if (item_i.last) begin
                conv_cols_d = eff_cols;
                wr_ptr_d    = '0;
                if (new_cnt != '0) begin
                  state_d = S_DRAIN;
                end
              end
            end
            CmdReadPtr: begin
              if (!conv_q) begin
                res_v_d = 1'b1;
                res_d.status = StNotConv;
              end else if (item_i.index > conv_cols_q) begin
                res_v_d = 1'b1;
                res_d.status = StIndex;
              end else begin
                lo_d    = '0;
                hi_d    = cnt_q;
                state_d = S_SRCH;
              end
            end
            CmdReadEnt: begin
              if (!conv_q) begin
                res_v_d = 1'b1;
                res_d.status = StNotConv;
              end else if (CntW'(item_i.index) >= cnt_q) begin
                res_v_d = 1'b1;
                res_d.status = StIndex;
              end else begin
                rd_en   = 1'b1;
                state_d = S_RDENT;
              end
            end
            default: begin
              res_v_d = 1'b1;
              res_d.status = StIndex;
            end
          endcase
        end
      end
      S_DRAIN: begin
        ctl.shift = 1'b1;
        wr_ptr_d  = wr_ptr_q + 1'b1;
        if (CntW'(wr_ptr_q) == cnt_q - 1'b1) begin
          state_d = S_IDLE;
        end
      end
      S_RDENT: begin
        res_v_d         = 1'b1;
        res_d.status    = StOk;
        res_d.row_out   = rd_q.row;
        res_d.value_out = rd_q.value;
        state_d         = S_IDLE;
      end
      S_SRCH: begin
        if (lo_q == hi_q) begin
          res_v_d         = 1'b1;
          res_d.status    = StOk;
          res_d.col_start = 13'(lo_q);
          state_d         = S_IDLE;
        end else begin
          mid_d   = mid_sum[CntW-1:0];
          rd_en   = 1'b1;
          rd_addr = mid_sum[AddrW-1:0];
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if ({1'b0, rd_q.col} < idx_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SRCH;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      num_cols_q <= 13'(MaxCols);
      cnt_q      <= '0;
      conv_q     <= 1'b0;
      conv_cols_q <= '0;
      wr_ptr_q   <= '0;
      res_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        num_cols_q <= cfg_data_i;
      end
      cnt_q      <= cnt_d;
      conv_q     <= conv_d;
      conv_cols_q <= conv_cols_d;
      wr_ptr_q   <= wr_ptr_d;
      res_v_q    <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  // sorted entry memory: written during drain, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == S_DRAIN) begin
      mem[wr_ptr_q] <= head_e;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  c2c_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .head_e_o (head_e),
    .head_v_o (head_v)
  );

  assign busy_o         = state_q != S_IDLE;
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // drain only moves real entries out of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> head_v)
    else $error("drain of empty cell row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxEntries))
    else $error("entry count overflow");

  // a read before conversion answers at once with not-converted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !conv_q && (item_i.command == CmdReadPtr || item_i.command == CmdReadEnt))
    |=> (result_valid_o && result_o.status == StNotConv))
    else $error("read before conversion not flagged");

  // a last load with stored entries always drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.command == CmdLoad && item_i.last && new_cnt != '0)
    |=> (state_q == S_DRAIN))
    else $error("conversion did not start");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for coo_to_csc_converter_unit: directed tests, then random sets.
// Depends on c2c_pkg and the converter RTL; a built-in predictor supplies expected results.
module testbench;
  import c2c_pkg::*;

  // command code with no operation behind it
  localparam logic [1:0] CmdBad = 2'd3;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  c2c_in_t  item_i = '0;
  logic     result_valid_o;
  c2c_out_t result_o;
  logic     cfg_we_i = 1'b0;
  logic [12:0] cfg_data_i = '0;

  coo_to_csc_converter_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .item_i(item_i), .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [12:0]        cols_reg;
  logic [14:0]        ent_row [MaxEntries];
  logic [11:0]        ent_col [MaxEntries];
  logic signed [15:0] ent_val [MaxEntries];
  int unsigned        ptr_tab [MaxCols + 1];
  int unsigned        n_loaded;
  bit                 is_converted;
  int unsigned        conv_ncols;

  c2c_out_t pending_results[$];
  int       err_count = 0;
  bit       no_gaps = 1'b0;

  function automatic int unsigned eff_cols();
    return (cols_reg < MaxCols) ? cols_reg : MaxCols;
  endfunction

  // stable sort by {col, row}, then prefix-sum per-column counts
  function automatic void convert_set();
    int unsigned n;
    int j;
    logic [26:0] k;
    logic [14:0] r;
    logic [11:0] c;
    logic signed [15:0] v;
    n = eff_cols();
    for (int i = 1; i < n_loaded; i++) begin
      r = ent_row[i]; c = ent_col[i]; v = ent_val[i]; k = {c, r};
      j = i;
      while (j > 0 && {ent_col[j-1], ent_row[j-1]} > k) begin
        ent_row[j] = ent_row[j-1]; ent_col[j] = ent_col[j-1]; ent_val[j] = ent_val[j-1];
        j--;
      end
      ent_row[j] = r; ent_col[j] = c; ent_val[j] = v;
    end
    for (int i = 0; i <= MaxCols; i++) ptr_tab[i] = 0;
    for (int i = 0; i < n_loaded; i++)
      if (ent_col[i] < n) ptr_tab[ent_col[i] + 1]++;
    for (int i = 0; i < n; i++) ptr_tab[i+1] += ptr_tab[i];
    conv_ncols = n;
    is_converted = 1'b1;
  endfunction

  function automatic c2c_out_t predict_result(c2c_in_t it);
    c2c_out_t o;
    o = '0;
    o.status = StOk;
    case (it.command)
      CmdLoad: begin
        if (is_converted) begin
          n_loaded = 0;
          is_converted = 1'b0;
        end
        if (it.col >= eff_cols()) o.status = StCol;
        else if (n_loaded >= MaxEntries) o.status = StFull;
        else begin
          ent_row[n_loaded] = it.row;
          ent_col[n_loaded] = it.col;
          ent_val[n_loaded] = it.value;
          n_loaded++;
        end
        if (it.last) convert_set();
      end
      CmdReadPtr: begin
        if (!is_converted) o.status = StNotConv;
        else if (it.index > conv_ncols) o.status = StIndex;
        else o.col_start = 13'(ptr_tab[it.index]);
      end
      CmdReadEnt: begin
        if (!is_converted) o.status = StNotConv;
        else if (it.index >= n_loaded) o.status = StIndex;
        else begin
          o.row_out = ent_row[it.index];
          o.value_out = ent_val[it.index];
        end
      end
      default: o.status = StIndex;
    endcase
    o.entry_count = 13'(n_loaded);
    return o;
  endfunction

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk_i) begin
    c2c_out_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer, status %0d", result_o.status);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_o.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, result_o.status); err_count++;
        end
        if (result_o.col_start !== exp_r.col_start) begin
          $error("col_start exp %0d got %0d", exp_r.col_start, result_o.col_start);
          err_count++;
        end
        if (result_o.row_out !== exp_r.row_out) begin
          $error("row_out exp %0d got %0d", exp_r.row_out, result_o.row_out); err_count++;
        end
        if (result_o.value_out !== exp_r.value_out) begin
          $error("value_out exp %0d got %0d", exp_r.value_out, result_o.value_out);
          err_count++;
        end
        if (result_o.entry_count !== exp_r.entry_count) begin
          $error("entry_count exp %0d got %0d", exp_r.entry_count, result_o.entry_count);
          err_count++;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_gaps) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic c2c_in_t mk_item(logic [1:0] cmd, logic [11:0] col, logic lst,
                                      logic [12:0] idx);
    c2c_in_t it;
    it.command = cmd;
    it.row = 15'($urandom());
    it.col = col;
    it.value = 16'($urandom());
    it.last = lst;
    it.index = idx;
    return it;
  endfunction

  // one command transfer; start stays high when no gap follows
  task automatic send_item(c2c_in_t it);
    int unsigned g;
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_result(it));
    g = pick_gap();
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // hold off until all results are in and the drain has finished
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_cols(logic [12:0] v);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cols_reg = v;
    @(posedge clk_i);
  endtask

  task automatic read_back(int unsigned nreads);
    for (int i = 0; i < nreads; i++) begin
      if ($urandom_range(1)) send_item(mk_item(CmdReadPtr, 12'($urandom()), 1'b0,
                                               13'($urandom_range(conv_ncols + 1))));
      else send_item(mk_item(CmdReadEnt, 12'($urandom()), 1'b0,
                             13'($urandom_range(n_loaded))));
    end
  endtask

  task automatic test_unconverted();
    send_item(mk_item(CmdReadPtr, 0, 1'b0, 0));
    send_item(mk_item(CmdReadEnt, 0, 1'b0, 13'h1fff));
    send_item(mk_item(CmdBad, 0, 1'b0, 0));
  endtask

  task automatic test_load_extremes();
    c2c_in_t it;
    it = mk_item(CmdLoad, 12'hfff, 1'b0, 0); it.row = 15'h7fff; it.value = 16'sh8000;
    send_item(it);
    it = mk_item(CmdLoad, 0, 1'b0, 13'h1fff); it.row = 0; it.value = 16'sh7fff;
    send_item(it);
    // exact duplicates keep arrival order
    it = mk_item(CmdLoad, 7, 1'b0, 0); it.row = 3; it.value = 11; send_item(it);
    it.value = -11; send_item(it);
    it = mk_item(CmdLoad, 7, 1'b0, 0); it.row = 2; send_item(it);
    send_item(mk_item(CmdReadEnt, 0, 1'b0, 0));   // not yet converted
    it = mk_item(CmdLoad, 7, 1'b1, 0); it.row = 3; it.value = 99; send_item(it);
    for (int i = 0; i < 6; i++) send_item(mk_item(CmdReadEnt, 0, 1'b0, 13'(i)));
    foreach (ptr_tab[j]) if (j inside {0, 1, 7, 8, 4095, 4096, 4097})
      send_item(mk_item(CmdReadPtr, 0, 1'b0, 13'(j)));
    send_item(mk_item(CmdReadPtr, 0, 1'b0, 13'h1fff));
    send_item(mk_item(CmdBad, 0, 1'b0, 1));
  endtask

  task automatic test_col_range();
    write_cols(1);
    send_item(mk_item(CmdLoad, 0, 1'b0, 0));   // starts a new set
    send_item(mk_item(CmdLoad, 1, 1'b0, 0));
    send_item(mk_item(CmdLoad, 12'hfff, 1'b1, 0)); // rejected last still converts
    read_back(4);
    send_item(mk_item(CmdReadPtr, 0, 1'b0, 2));
    write_cols(0);
    send_item(mk_item(CmdLoad, 0, 1'b1, 0));
    send_item(mk_item(CmdReadPtr, 0, 1'b0, 0));
    send_item(mk_item(CmdReadEnt, 0, 1'b0, 0));
    write_cols(13'h1fff);
    send_item(mk_item(CmdLoad, 12'hfff, 1'b1, 0));
    send_item(mk_item(CmdReadPtr, 0, 1'b0, 4096));
  endtask

  task automatic test_cols_midset();
    write_cols(64);
    for (int i = 0; i < 6; i++)
      send_item(mk_item(CmdLoad, 12'($urandom_range(63)), 1'b0, 0));
    write_cols(8);
    send_item(mk_item(CmdLoad, 3, 1'b1, 0));
    read_back(12);
    send_item(mk_item(CmdReadPtr, 0, 1'b0, 8));
    send_item(mk_item(CmdReadPtr, 0, 1'b0, 9));
  endtask

  task automatic test_full_store();
    write_cols(4096);
    no_gaps = 1'b1;
    for (int i = 0; i < MaxEntries; i++)
      send_item(mk_item(CmdLoad, 12'($urandom()), 1'b0, 0));
    send_item(mk_item(CmdLoad, 5, 1'b0, 0));
    send_item(mk_item(CmdLoad, 6, 1'b1, 0));
    no_gaps = 1'b0;
    read_back(30);
    send_item(mk_item(CmdReadEnt, 0, 1'b0, 4095));
    send_item(mk_item(CmdReadEnt, 0, 1'b0, 4096));
    send_item(mk_item(CmdReadPtr, 0, 1'b0, 4096));
  endtask

  task automatic test_random_sets();
    int unsigned sent;
    int unsigned nset;
    logic [12:0] cfgs [6] = '{13'd1, 13'd2, 13'd16, 13'd300, 13'd4096, 13'd8191};
    sent = 0;
    while (sent < 1700) begin
      if ($urandom_range(3) == 0) write_cols(cfgs[$urandom_range(5)]);
      else if ($urandom_range(9) == 0) write_cols(13'($urandom_range(4096, 1)));
      no_gaps = ($urandom_range(4) == 0);
      nset = ($urandom_range(9) == 0) ? $urandom_range(120, 20) : $urandom_range(12, 1);
      for (int i = 0; i < nset; i++) begin
        int unsigned p;
        logic [11:0] c;
        p = $urandom_range(99);
        c = (p < 85 && eff_cols() > 0) ? 12'($urandom_range(eff_cols() - 1))
                                       : 12'($urandom());
        if (p >= 95) send_item(mk_item(2'($urandom_range(3, 1)), c, 1'b0, 13'($urandom())));
        else send_item(mk_item(CmdLoad, c, (i == nset - 1), 0));
        sent++;
        if (i == nset / 2 && $urandom_range(7) == 0) write_cols(13'($urandom_range(8191)));
      end
      nset = $urandom_range(20, 2);
      read_back(nset);
      sent += nset;
      if ($urandom_range(5) == 0) begin
        send_item(mk_item(CmdReadPtr, 0, 1'b0, 13'($urandom())));
        send_item(mk_item(CmdBad, 12'($urandom()), 1'($urandom()), 13'($urandom())));
        sent += 2;
      end
    end
  endtask

  initial begin
    cols_reg = 13'd4096;
    n_loaded = 0;
    is_converted = 1'b0;
    conv_ncols = 0;
    foreach (ptr_tab[i]) ptr_tab[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unconverted();
    test_load_extremes();
    test_col_range();
    test_cols_midset();
    test_full_store();
    test_random_sets();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
